// ===== sv/sed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the squared distance core
// Queue entry and status types, floating-point special codes, queue depth.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int SED_FIFO_DEPTH = 4;

  localparam logic [63:0] DBL_CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] DBL_POS_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_POS_ZERO  = 64'h0000_0000_0000_0000;

  // One squared term on its way from the front end to the accumulator
  typedef struct packed {
    logic        last;
    logic [63:0] term;
  } sed_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sed_q_stat_t;

endpackage : sed_pkg
`default_nettype wire

// ===== sv/sed_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_front: single-precision difference and exact square
// Three stages: align and add, normalize and round, multiply; pack to double.
// ----------------------------------------------------------------------------
module sed_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [63:0]            in_tdata,   // [31:0] elem_a, [63:32] elem_b
  input  logic                   in_tlast,   // last
  output logic                   push,
  output sed_pkg::sed_item_t     push_item,
  input  sed_pkg::sed_q_stat_t   q_stat
);
  import sed_pkg::*;

  // stage enables
  logic en1, en2, en3;

  // stage 1: unpack, swap, align, add or subtract
  logic [31:0] a, b;
  logic        a_nan, b_nan, a_inf, b_inf, a_ge, eff_sub;
  logic [23:0] ma, mb, mx, my;
  logic [7:0]  ea, eb, ex, ey, sh;
  logic [26:0] yw_full, yw;
  logic        stk;
  logic [27:0] sum_nxt;

  logic        s1_v_r, s1_nan_r, s1_inf_r, s1_last_r;
  logic [27:0] s1_sum_r;
  logic [7:0]  s1_exp_r;

  // stage 2: normalize and round
  logic [4:0]         lz;
  logic               found;
  logic [26:0]        m27;
  logic signed [9:0]  e_pre, e_nxt;
  logic               rup;
  logic [24:0]        mant25;
  logic [23:0]        mant_nxt;

  logic               s2_v_r, s2_nan_r, s2_inf_r, s2_zero_r, s2_last_r;
  logic [23:0]        s2_mant_r;
  logic signed [9:0]  s2_exp_r;

  // stage 3: square
  logic               s3_v_r, s3_nan_r, s3_inf_r, s3_zero_r, s3_last_r;
  logic [47:0]        s3_prod_r;
  logic signed [9:0]  s3_exp_r;
  logic [11:0]        dexp;
  logic [51:0]        dfrac;

  assign en3       = !s3_v_r || !q_stat.full;
  assign en2       = !s2_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_tready = en1;

  assign a     = in_tdata[31:0];
  assign b     = in_tdata[63:32];
  assign a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  assign b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  assign a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  assign b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  assign ma    = {a[30:23] != 8'd0, a[22:0]};
  assign mb    = {b[30:23] != 8'd0, b[22:0]};
  assign ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  assign eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  assign a_ge  = a[30:0] >= b[30:0];
  assign eff_sub = a[31] == b[31];
  assign mx    = a_ge ? ma : mb;
  assign my    = a_ge ? mb : ma;
  assign ex    = a_ge ? ea : eb;
  assign ey    = a_ge ? eb : ea;
  assign sh    = ex - ey;
  assign yw_full = {my, 3'b000};

  always_comb begin
    if (sh >= 8'd27) begin
      yw  = '0;
      stk = |my;
    end else begin
      yw  = yw_full >> sh;
      stk = |(yw_full & ~({27{1'b1}} << sh));
    end
    yw[0] = yw[0] | stk;
    if (eff_sub) begin
      sum_nxt = {1'b0, mx, 3'b000} - {1'b0, yw};
    end else begin
      sum_nxt = {1'b0, mx, 3'b000} + {1'b0, yw};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_tvalid;
    end
    if (en1) begin
      s1_nan_r  <= a_nan || b_nan || (a_inf && b_inf && (a[31] == b[31]));
      s1_inf_r  <= a_inf || b_inf;
      s1_sum_r  <= sum_nxt;
      s1_exp_r  <= ex;
      s1_last_r <= in_tlast;
    end
  end

  // leading zero count of the 27 bits below the carry
  always_comb begin
    lz    = '0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && s1_sum_r[i]) begin
        lz    = 5'(26 - i);
        found = 1'b1;
      end
    end
  end

  // Normalize without the subnormal clamp: a sum below the normal range is
  // exact, so its round bits are zero and the value is kept as is.
  always_comb begin
    if (s1_sum_r[27]) begin
      m27   = {s1_sum_r[27:2], s1_sum_r[1] | s1_sum_r[0]};
      e_pre = 10'({2'b00, s1_exp_r}) + 10'sd1;
    end else begin
      m27   = s1_sum_r[26:0] << lz;
      e_pre = 10'({2'b00, s1_exp_r}) - 10'({5'd0, lz});
    end
    rup    = m27[2] & (m27[1] | m27[0] | m27[3]);
    mant25 = {1'b0, m27[26:3]} + {24'd0, rup};
    if (mant25[24]) begin
      mant_nxt = 24'h80_0000;
      e_nxt    = e_pre + 10'sd1;
    end else begin
      mant_nxt = mant25[23:0];
      e_nxt    = e_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
    if (en2) begin
      s2_nan_r  <= s1_nan_r;
      s2_inf_r  <= !s1_nan_r && (s1_inf_r || (e_nxt >= 10'sd255));
      s2_zero_r <= s1_sum_r == 28'd0;
      s2_mant_r <= mant_nxt;
      s2_exp_r  <= e_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
    if (en3) begin
      s3_nan_r  <= s2_nan_r;
      s3_inf_r  <= s2_inf_r;
      s3_zero_r <= s2_zero_r;
      s3_prod_r <= s2_mant_r * s2_mant_r;
      s3_exp_r  <= s2_exp_r;
      s3_last_r <= s2_last_r;
    end
  end

  // The square of a normalized 24-bit significand fits a double exactly
  assign dexp  = 12'({s3_exp_r[9], s3_exp_r, 1'b0}) +
                 (s3_prod_r[47] ? 12'd770 : 12'd769);
  assign dfrac = s3_prod_r[47] ? {s3_prod_r[46:0], 5'd0} : {s3_prod_r[45:0], 6'd0};

  always_comb begin
    push_item.last = s3_last_r;
    if (s3_nan_r) begin
      push_item.term = DBL_CANON_NAN;
    end else if (s3_inf_r) begin
      push_item.term = DBL_POS_INF;
    end else if (s3_zero_r) begin
      push_item.term = DBL_POS_ZERO;
    end else begin
      push_item.term = {1'b0, dexp[10:0], dfrac};
    end
  end

  assign push = s3_v_r && !q_stat.full;

endmodule : sed_front
`default_nettype wire

// ===== sv/sed_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_fifo: short queue of squared terms
// Decouples the front end from the accumulator.
// ----------------------------------------------------------------------------
module sed_fifo #(
  parameter int DEPTH = sed_pkg::SED_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sed_pkg::sed_item_t    push_item,
  input  logic                  pop,
  output sed_pkg::sed_item_t    head,
  output sed_pkg::sed_q_stat_t  stat
);
  import sed_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sed_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  assign stat.full  = count_r == CW'(DEPTH);
  assign stat.empty = count_r == '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : sed_fifo
`default_nettype wire

// ===== sv/sed_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_back: double accumulator and result register
// Adds one nonnegative term per cycle if unstalled; emits and clears on last.
// ----------------------------------------------------------------------------
module sed_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sed_pkg::sed_item_t    head,
  input  sed_pkg::sed_q_stat_t  q_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata
);
  import sed_pkg::*;

  logic [63:0] acc_r, sum;
  logic [63:0] out_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic        can_out;

  logic        acc_nan, acc_inf, acc_zero, t_nan, t_inf, t_zero, t_big;
  logic [10:0] ex, ey, sh;
  logic [52:0] mx, my;
  logic [55:0] yw_full, yw;
  logic        stk;
  logic [56:0] sum57;
  logic [55:0] m56;
  logic [11:0] e_pre, e_fin;
  logic        rup;
  logic [53:0] mant54;
  logic [51:0] frac;

  assign acc_nan  = (acc_r[62:52] == 11'h7FF) && (acc_r[51:0] != 52'd0);
  assign acc_inf  = (acc_r[62:52] == 11'h7FF) && (acc_r[51:0] == 52'd0);
  assign acc_zero = acc_r[62:0] == 63'd0;
  assign t_nan    = (head.term[62:52] == 11'h7FF) && (head.term[51:0] != 52'd0);
  assign t_inf    = (head.term[62:52] == 11'h7FF) && (head.term[51:0] == 52'd0);
  assign t_zero   = head.term[62:0] == 63'd0;

  // both operands are nonnegative normals here: swap on exponent only
  assign t_big   = head.term[62:52] > acc_r[62:52];
  assign ex      = t_big ? head.term[62:52] : acc_r[62:52];
  assign ey      = t_big ? acc_r[62:52] : head.term[62:52];
  assign mx      = {1'b1, t_big ? head.term[51:0] : acc_r[51:0]};
  assign my      = {1'b1, t_big ? acc_r[51:0] : head.term[51:0]};
  assign sh      = ex - ey;
  assign yw_full = {my, 3'b000};

  always_comb begin
    if (sh >= 11'd56) begin
      yw  = '0;
      stk = 1'b1;
    end else begin
      yw  = yw_full >> sh;
      stk = |(yw_full & ~({56{1'b1}} << sh));
    end
    yw[0] = yw[0] | stk;
    sum57 = {1'b0, mx, 3'b000} + {1'b0, yw};
    if (sum57[56]) begin
      m56   = {sum57[56:2], sum57[1] | sum57[0]};
      e_pre = {1'b0, ex} + 12'd1;
    end else begin
      m56   = sum57[55:0];
      e_pre = {1'b0, ex};
    end
    rup    = m56[2] & (m56[1] | m56[0] | m56[3]);
    mant54 = {1'b0, m56[55:3]} + {53'd0, rup};
    if (mant54[53]) begin
      frac  = '0;
      e_fin = e_pre + 12'd1;
    end else begin
      frac  = mant54[51:0];
      e_fin = e_pre;
    end

    if (acc_nan || t_nan) begin
      sum = DBL_CANON_NAN;
    end else if (acc_inf || t_inf || (e_fin >= 12'd2047)) begin
      sum = DBL_POS_INF;
    end else if (acc_zero) begin
      sum = head.term;
    end else if (t_zero) begin
      sum = acc_r;
    end else begin
      sum = {1'b0, e_fin[10:0], frac};
    end
  end

  assign can_out    = !out_valid_r || out_tready;
  assign pop        = !q_stat.empty && (!head.last || can_out);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // drop the result once taken, raise it again on a popped last term
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && head.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= DBL_POS_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (head.last) begin
          acc_r <= DBL_POS_ZERO;
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_data_r <= sum;
    end
  end

endmodule : sed_back
`default_nettype wire

// ===== sv/squared_euclidean_distance_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// squared_euclidean_distance_core: streaming squared Euclidean distance
// Sums (a - b)^2 over pairs of single-precision elements into a double.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one element pair (elem_a, elem_b as float bit patterns)
//   and tlast on the final pair of the vectors. Each pair's difference is
//   rounded in single precision, squared exactly in double and added to a
//   double accumulator in arrival order (round to nearest even).
//   On a tlast beat one output beat carries the double sum; the accumulator
//   then returns to +0. A NaN sum comes out as the canonical quiet NaN.
//   Throughput: one pair per cycle when nothing stalls, set by the double add in the
//   accumulator loop. After the edge that accepts a tlast beat, the pair passes
//   the three front stages and a queue write, then the accumulator loads the
//   output register and out_tvalid rises.
//   Reset (rst_n low, synchronous) empties the pipeline and queue, drops any
//   pending result and clears the accumulator to +0.
//   When the receiver stalls, the result holds in the output register while
//   non-last pairs keep flowing; the front end stalls only once the queue
//   fills behind a waiting last pair.
// ----------------------------------------------------------------------------
module squared_euclidean_distance_core #(
  parameter int FIFO_DEPTH = sed_pkg::SED_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] elem_a, [63:32] elem_b
  input  logic        in_tlast,    // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata    // [63:0] distance
);
  import sed_pkg::*;

  sed_item_t   push_item, head;
  sed_q_stat_t q_stat;
  logic        push, pop;

  // difference, square and pack to double
  sed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_item (push_item),
    .q_stat    (q_stat)
  );

  // term queue between the two halves
  sed_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // accumulate and hold the result
  sed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // sum of squares is never negative
  a_sign_clear : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[63])
    else $error("distance has sign bit set");

  // special exponents only as +inf or the canonical NaN
  a_special_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[62:52] == 11'h7FF)) |->
      ((out_tdata[51:0] == 52'd0) || (out_tdata[51:0] == 52'h8_0000_0000_0000)))
    else $error("non-canonical special value on output");

  // a full queue never takes a push without a pop
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !(push && !pop))
    else $error("term queue overflow");
`endif

endmodule : squared_euclidean_distance_core
`default_nettype wire

// ===== tb/squared_euclidean_distance_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// squared_euclidean_distance_core_tb: self-checking bench of the distance core
// Streams vectors of float element pairs with random gaps and stalls, predicts
// each double distance bit for bit and compares it with every output beat.
// ----------------------------------------------------------------------------
module squared_euclidean_distance_core_tb;
  import sed_pkg::*;

  typedef struct {
    logic [31:0] elem_a;
    logic [31:0] elem_b;
    logic        last;
  } pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] elem_a, [63:32] elem_b
  logic        in_tlast = 1'b0; // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] distance

  pair_t       pair_q[$];       // beats waiting for the driver
  logic [63:0] dist_q[$];       // predicted distances, oldest first
  real         dist_acc;        // running sum of squared differences
  int          mismatches = 0;
  bit          in_fire = 0;     // input beat accepted at the last rising edge
  bit          out_fire = 0;    // output beat accepted at the last rising edge
  bit          stim_done = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_calm = 0;     // stretch with no input gaps
  bit          out_calm = 0;    // stretch with no output stalls

  squared_euclidean_distance_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // Widen a float bit pattern exactly to a double bit pattern.
  function automatic logic [63:0] widen_f32(input logic [31:0] f);
    logic [23:0] mm;
    int          ex;
    mm = {1'b0, f[22:0]};
    ex = 1023 - 126;
    if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'b0};
    if (f[30:23] != 8'h00) return {f[31], 11'(f[30:23] - 127 + 1023), f[22:0], 29'b0};
    if (f[22:0] == 23'b0) return {f[31], 63'b0};
    // subnormal: normalize the significand
    while (!mm[23]) begin
      mm = mm << 1;
      ex--;
    end
    return {f[31], 11'(ex), mm[22:0], 29'b0};
  endfunction

  // Round a double bit pattern to float, nearest even, with gradual underflow.
  function automatic logic [31:0] round_f32(input logic [63:0] d);
    logic [63:0] sig, kept, rem, half, packed_val;
    int          e8, sh;
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'h0};
    if (d[62:0] == 63'b0) return {d[63], 31'b0};
    sig = {11'b0, 1'b1, d[51:0]};
    e8 = int'(d[62:52]) - 1023 + 127;
    sh = (e8 >= 1) ? 29 : 29 + 1 - e8;
    if (sh > 60) sh = 60;
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept++;
    if (e8 < 1) return {d[63], kept[30:0]};
    packed_val = (64'(e8 - 1) << 23) + kept;
    if (packed_val >= (64'd255 << 23)) return {d[63], 8'hFF, 23'b0};
    return {d[63], packed_val[30:0]};
  endfunction

  // Fold one pair into the running sum; return 1 with the distance on last.
  function automatic bit fold_pair(input pair_t p, output logic [63:0] dist_bits);
    real diff, term;
    diff = $bitstoreal(widen_f32(p.elem_a)) - $bitstoreal(widen_f32(p.elem_b));
    diff = $bitstoreal(widen_f32(round_f32($realtobits(diff))));
    term = diff * diff;
    dist_acc = dist_acc + term;
    dist_bits = $realtobits(dist_acc);
    if (dist_bits[62:52] == 11'h7FF && dist_bits[51:0] != 0) dist_bits = DBL_CANON_NAN;
    if (!p.last) return 0;
    dist_acc = 0.0;
    return 1;
  endfunction

  // Draw one float operand: raw bits, tame magnitudes, subnormals or specials.
  function automatic logic [31:0] draw_f32();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5, 6: return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
      7: return {1'($urandom), 8'h00, 23'($urandom)};
      8: return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom_range(0, 3))};
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'($urandom), 31'h7F80_0000};
          1: return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
          2: return {1'($urandom), 31'h7F7F_FFFF};
          3: return {1'($urandom), 31'h0};
          default: return {1'($urandom), 31'h0000_0001};
        endcase
      end
    endcase
  endfunction

  task automatic push_pair(input logic [31:0] a, input logic [31:0] b, input logic last);
    pair_t p;
    p.elem_a = a;
    p.elem_b = b;
    p.last   = last;
    pair_q.push_back(p);
  endtask

  // Driver: advance on the falling edge, hold a beat until it is taken.
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_fire)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pair_q.size() > 0) begin
        pair_t p;
        p = pair_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {p.elem_b, p.elem_a};
        in_tlast  <= p.last;
        if ($urandom_range(0, 63) == 0) in_calm = ~in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 8);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    // Receiver: draw a stall after each result, raise ready as it runs out.
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 15) == 0) out_calm = ~out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 8);
        out_tready <= (out_stall == 0);
      end else if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted input beats, check accepted output beats.
  always @(posedge clk) begin
    pair_t       p;
    logic [63:0] dist_bits, exp_dist;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      p.elem_a = in_tdata[31:0];
      p.elem_b = in_tdata[63:32];
      p.last   = in_tlast;
      if (fold_pair(p, dist_bits)) dist_q.push_back(dist_bits);
    end
    if (out_fire) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance beat %h", out_tdata);
      end else begin
        exp_dist = dist_q.pop_front();
        if (out_tdata !== exp_dist) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %h, got %h", exp_dist, out_tdata);
        end
      end
    end
  end

  initial begin
    int len;
    dist_acc = 0.0;
    // Directed vectors: zeros, signed zeros, extremes, specials, length one.
    push_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
    push_pair(32'h8000_0000, 32'h0000_0000, 1'b1);
    push_pair(32'h3F80_0000, 32'h4000_0000, 1'b0);
    push_pair(32'h4040_0000, 32'h3F80_0000, 1'b1);
    push_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0);       // difference rounds to inf
    push_pair(32'h7F7F_FFFF, 32'h0000_0000, 1'b1);
    push_pair(32'h7F80_0000, 32'h0000_0000, 1'b1);       // infinite input
    push_pair(32'h7F80_0000, 32'h7F80_0000, 1'b1);       // inf minus inf
    push_pair(32'hFF80_0000, 32'hFF80_0000, 1'b0);
    push_pair(32'h3F80_0000, 32'h0000_0000, 1'b1);
    push_pair(32'h7FC0_1234, 32'h3F80_0000, 1'b1);       // NaN with payload
    push_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    push_pair(32'h0000_0001, 32'h8000_0001, 1'b1);       // subnormals
    push_pair(32'h007F_FFFF, 32'h0000_0001, 1'b0);
    push_pair(32'h0080_0000, 32'h807F_FFFF, 1'b1);
    push_pair(32'h4B80_0001, 32'h3F00_0000, 1'b1);       // rounding above the halfway point
    push_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    push_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    // Random vectors, mostly short.
    while (pair_q.size() < 1120) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) push_pair(draw_f32(), draw_f32(), i == len - 1);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pair_q.size() == 0 && !in_tvalid);
    stim_done = 1;
    wait (dist_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && dist_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sed_pkg.sv
sv/sed_front.sv
sv/sed_fifo.sv
sv/sed_back.sv
sv/squared_euclidean_distance_core.sv
tb/squared_euclidean_distance_core_tb.sv
